### rtl/price_level_book_update_core_defines.svh
// Assertion macros for the price level book core.
`ifndef PRICE_LEVEL_BOOK_UPDATE_CORE_DEFINES_SVH
`define PRICE_LEVEL_BOOK_UPDATE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PLBU_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define PLBU_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PLBU_CHECK(lbl, ante, cons, msg)
`define PLBU_CHECK_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/plbu_pkg.sv
`timescale 1ns / 1ps
package plbu_pkg;
    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_DEL   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [2:0] ET_LAST  = 3'd3;

    localparam logic [2:0] OUT_UPDATED    = 3'd0;
    localparam logic [2:0] OUT_INSERTED   = 3'd1;
    localparam logic [2:0] OUT_REMOVED    = 3'd2;
    localparam logic [2:0] OUT_BAD_DELETE = 3'd3;
    localparam logic [2:0] OUT_FULL       = 3'd4;
    localparam logic [2:0] OUT_IGNORED    = 3'd5;
    localparam logic [2:0] OUT_CLEARED    = 3'd6;

    typedef enum logic [1:0] {
        K_SET, K_DEL, K_CLEAR, K_IGNORE
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [1:0] et;
    } cmd_t;
endpackage

### rtl/price_level_book_update_core.sv
// Sequence: clear and ignored requests go straight to the centre step; other requests scan
// the rows, then move rows and write a row as needed; scanned plus moved rows never exceed
// LEVELS. Output stalls hold the back end in its output state.
// Back end: one request at a time, the next is taken only once the row scan and the row
// move through the table memory are done. Two requests queue in front.
// Reset: synchronous, active low on aresetn; empties the book and the queue, the table
// memory keeps its contents and is read only below the level count.
`timescale 1ns / 1ps
`include "price_level_book_update_core_defines.svh"
module price_level_book_update_core #(
    parameter int LEVELS     = 64,
    parameter int PRICE_BITS = 32,
    parameter int QTY_BITS   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // price_ticks [31:0], quantity [63:32]
    input  logic [4:0]  s_tuser,   // operation [1:0], entry_type [4:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // row [5:0], level_count [12:6], center_row [19:13], zero
    output logic [2:0]  m_tuser    // outcome [2:0]
);
    import plbu_pkg::*;

    logic                  q_valid, q_ready;
    cmd_t                  q_cmd;
    logic [PRICE_BITS-1:0] q_price;
    logic [QTY_BITS-1:0]   q_qty;
    logic [5:0]            res_row;
    logic [6:0]            res_count, res_center;

    // front end: take the request, classify it, hold it in a short queue
    plbu_front #(.PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser[1:0]),
        .in_et    (s_tuser[4:2]),
        .in_price (s_tdata[31:0]),
        .in_qty   (s_tdata[63:32]),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .q_price  (q_price),
        .q_qty    (q_qty)
    );

    // back end: scan, move rows, write the level, work out the centre
    plbu_back #(.LEVELS(LEVELS), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_cmd       (q_cmd),
        .q_price     (q_price),
        .q_qty       (q_qty),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_outcome (m_tuser),
        .res_row     (res_row),
        .res_count   (res_count),
        .res_center  (res_center)
    );

    assign m_tdata = {4'd0, res_center, res_count, res_row};

    `PLBU_CHECK(a_clear_empty, m_tvalid && m_tuser == OUT_CLEARED, m_tdata[12:6] == 7'd0, "clear left levels")
    `PLBU_CHECK(a_insert_nonempty, m_tvalid && m_tuser == OUT_INSERTED, m_tdata[12:6] != 7'd0, "insert with empty book")
    `PLBU_CHECK(a_full_count, m_tvalid && m_tuser == OUT_FULL, m_tdata[12:6] == 7'(LEVELS), "drop while not full")
    `PLBU_CHECK(a_no_row, m_tvalid && (m_tuser == OUT_BAD_DELETE || m_tuser == OUT_IGNORED), m_tdata[5:0] == 6'd0, "row on untouched result")
endmodule

### rtl/plbu_ram.sv
`timescale 1ns / 1ps
module plbu_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### rtl/plbu_front.sv
`timescale 1ns / 1ps
module plbu_front #(
    parameter int PRICE_BITS = 32,
    parameter int QTY_BITS   = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_op,
    input  logic [2:0]            in_et,
    input  logic [31:0]           in_price,
    input  logic [31:0]           in_qty,
    output logic                  q_valid,
    input  logic                  q_ready,
    output plbu_pkg::cmd_t        q_cmd,
    output logic [PRICE_BITS-1:0] q_price,
    output logic [QTY_BITS-1:0]   q_qty
);
    import plbu_pkg::*;

    cmd_t                  cmd_mem   [2];
    logic [PRICE_BITS-1:0] price_mem [2];
    logic [QTY_BITS-1:0]   qty_mem   [2];
    logic                  wr_ptr_reg, rd_ptr_reg;
    logic [1:0]            count_reg;
    cmd_t                  cls;
    logic [63:0]           price_ext, qty_ext;
    logic                  push, pop;

    // classify the request
    always_comb begin
        cls.et = in_et[1:0];
        if (in_op == OP_CLEAR) begin
            cls.kind = K_CLEAR;
        end else if ((in_op == OP_SET || in_op == OP_DEL) && in_et <= ET_LAST) begin
            cls.kind = (in_op == OP_DEL) ? K_DEL : K_SET;
        end else begin
            cls.kind = K_IGNORE;
        end
    end

    assign price_ext = {32'd0, in_price};
    assign qty_ext   = {32'd0, in_qty};
    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign q_valid   = (count_reg != 2'd0);
    assign pop       = q_valid && q_ready;
    assign q_cmd     = cmd_mem[rd_ptr_reg];
    assign q_price   = price_mem[rd_ptr_reg];
    assign q_qty     = qty_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            cmd_mem[wr_ptr_reg]   <= cls;
            price_mem[wr_ptr_reg] <= price_ext[PRICE_BITS-1:0];
            qty_mem[wr_ptr_reg]   <= qty_ext[QTY_BITS-1:0];
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### rtl/plbu_back.sv
`timescale 1ns / 1ps
module plbu_back #(
    parameter int LEVELS     = 64,
    parameter int PRICE_BITS = 32,
    parameter int QTY_BITS   = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  plbu_pkg::cmd_t        q_cmd,
    input  logic [PRICE_BITS-1:0] q_price,
    input  logic [QTY_BITS-1:0]   q_qty,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [2:0]            res_outcome,
    output logic [5:0]            res_row,
    output logic [6:0]            res_count,
    output logic [6:0]            res_center
);
    import plbu_pkg::*;

    localparam int AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW = $clog2(LEVELS + 1);
    localparam int W  = PRICE_BITS + 4 * QTY_BITS;
    localparam logic [CW-1:0] LEVELS_C = CW'(LEVELS);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CHK, S_DECIDE, S_SH_RD, S_SH_WR, S_WRITE, S_CENTER, S_OUT
    } state_t;

    state_t                state_reg;
    cmd_t                  cmd_reg;
    logic [PRICE_BITS-1:0] price_reg;
    logic [QTY_BITS-1:0]   qty_reg;
    logic [CW-1:0]         used_reg, idx_reg, pos_reg, center_reg;
    logic                  found_reg, up_reg;
    logic [W-1:0]          row_reg;
    logic [2:0]            outcome_reg;
    logic [CW-1:0]         row_out_reg;
    logic [LEVELS-1:0]     bidf_reg, askf_reg;
    logic                  out_valid_reg;
    logic [2:0]            out_outcome_reg;
    logic [5:0]            out_row_reg;
    logic [6:0]            out_count_reg, out_center_reg;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [W-1:0]          ram_wdata, ram_rdata;

    logic [W-1:0]          mod_row, ins_row;
    logic [QTY_BITS-1:0]   qb, qa, qib, qia;
    logic                  all_zero;
    logic [CW-1:0]         b_row, a_row;
    logic [CW:0]           mid_sum;

    plbu_ram #(.WIDTH(W), .DEPTH(LEVELS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr = idx_reg[AW-1:0];
    assign ram_we    = (state_reg == S_SH_WR) || (state_reg == S_WRITE);
    assign ram_waddr = (state_reg == S_WRITE) ? pos_reg[AW-1:0]
                     : (up_reg ? AW'(idx_reg + 1'b1) : AW'(idx_reg - 1'b1));
    assign ram_wdata = (state_reg == S_WRITE) ? row_reg : ram_rdata;
    assign q_ready   = (state_reg == S_IDLE);

    // found row with the addressed quantity replaced (zero on delete)
    always_comb begin
        mod_row = row_reg;
        mod_row[PRICE_BITS + 32'(cmd_reg.et) * QTY_BITS +: QTY_BITS] =
            (cmd_reg.kind == K_DEL) ? '0 : qty_reg;
        qb  = mod_row[PRICE_BITS +: QTY_BITS];
        qa  = mod_row[PRICE_BITS + QTY_BITS +: QTY_BITS];
        qib = mod_row[PRICE_BITS + 2 * QTY_BITS +: QTY_BITS];
        qia = mod_row[PRICE_BITS + 3 * QTY_BITS +: QTY_BITS];
        all_zero = ((qb | qa | qib | qia) == '0);
    end

    // new level: the price, the given quantity, zero elsewhere
    always_comb begin
        ins_row = '0;
        ins_row[PRICE_BITS-1:0] = price_reg;
        ins_row[PRICE_BITS + 32'(cmd_reg.et) * QTY_BITS +: QTY_BITS] = qty_reg;
    end

    // lowest bid row and highest ask row; flags above the used rows stay clear
    always_comb begin
        b_row = used_reg;
        a_row = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (bidf_reg[i]) b_row = CW'(i);
        end
        for (int i = 0; i < LEVELS; i++) begin
            if (askf_reg[i]) a_row = CW'(i);
        end
        mid_sum = {1'b0, b_row} + {1'b0, a_row} + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            bidf_reg      <= '0;
            askf_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= (state_reg == S_OUT) || (out_valid_reg && !res_ready);
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        cmd_reg     <= q_cmd;
                        price_reg   <= q_price;
                        qty_reg     <= q_qty;
                        idx_reg     <= '0;
                        pos_reg     <= '0;
                        found_reg   <= 1'b0;
                        row_out_reg <= '0;
                        unique case (q_cmd.kind)
                            K_CLEAR: begin
                                used_reg    <= '0;
                                bidf_reg    <= '0;
                                askf_reg    <= '0;
                                outcome_reg <= OUT_CLEARED;
                                state_reg   <= S_CENTER;
                            end
                            K_IGNORE: begin
                                outcome_reg <= OUT_IGNORED;
                                state_reg   <= S_CENTER;
                            end
                            default: begin
                                state_reg <= (used_reg == '0) ? S_DECIDE : S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN: state_reg <= S_CHK;
                S_CHK: begin
                    // rows hold strictly descending prices
                    if (ram_rdata[PRICE_BITS-1:0] == price_reg) begin
                        found_reg <= 1'b1;
                        pos_reg   <= idx_reg;
                        row_reg   <= ram_rdata;
                        state_reg <= S_DECIDE;
                    end else if ($signed(ram_rdata[PRICE_BITS-1:0]) < $signed(price_reg)) begin
                        pos_reg   <= idx_reg;
                        state_reg <= S_DECIDE;
                    end else if (idx_reg + 1'b1 == used_reg) begin
                        pos_reg   <= used_reg;
                        state_reg <= S_DECIDE;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_DECIDE: begin
                    if (cmd_reg.kind == K_DEL && !found_reg) begin
                        outcome_reg <= OUT_BAD_DELETE;
                        state_reg   <= S_CENTER;
                    end else if (found_reg && !(cmd_reg.kind == K_DEL && all_zero)) begin
                        row_reg               <= mod_row;
                        bidf_reg[pos_reg[AW-1:0]] <= ((qb | qib) != '0);
                        askf_reg[pos_reg[AW-1:0]] <= ((qa | qia) != '0);
                        outcome_reg           <= OUT_UPDATED;
                        row_out_reg           <= pos_reg;
                        state_reg             <= S_WRITE;
                    end else if (found_reg) begin
                        // remove the level: close the gap from above
                        for (int i = 0; i < LEVELS; i++) begin
                            if (CW'(i) >= pos_reg) begin
                                bidf_reg[i] <= (i + 1 < LEVELS) ? bidf_reg[(i + 1) % LEVELS] : 1'b0;
                                askf_reg[i] <= (i + 1 < LEVELS) ? askf_reg[(i + 1) % LEVELS] : 1'b0;
                            end
                        end
                        used_reg    <= used_reg - 1'b1;
                        outcome_reg <= OUT_REMOVED;
                        row_out_reg <= pos_reg;
                        up_reg      <= 1'b0;
                        idx_reg     <= pos_reg + 1'b1;
                        state_reg   <= (pos_reg < used_reg - 1'b1) ? S_SH_RD : S_CENTER;
                    end else if (used_reg >= LEVELS_C) begin
                        outcome_reg <= OUT_FULL;
                        state_reg   <= S_CENTER;
                    end else begin
                        // insert: open a gap at the sorted row
                        row_reg <= ins_row;
                        for (int i = 0; i < LEVELS; i++) begin
                            if (CW'(i) == pos_reg) begin
                                bidf_reg[i] <= (qty_reg != '0) && !cmd_reg.et[0];
                                askf_reg[i] <= (qty_reg != '0) && cmd_reg.et[0];
                            end else if (CW'(i) > pos_reg) begin
                                bidf_reg[i] <= bidf_reg[(i + LEVELS - 1) % LEVELS];
                                askf_reg[i] <= askf_reg[(i + LEVELS - 1) % LEVELS];
                            end
                        end
                        used_reg    <= used_reg + 1'b1;
                        outcome_reg <= OUT_INSERTED;
                        row_out_reg <= pos_reg;
                        up_reg      <= 1'b1;
                        idx_reg     <= used_reg - 1'b1;
                        state_reg   <= (pos_reg < used_reg) ? S_SH_RD : S_WRITE;
                    end
                end
                S_SH_RD: state_reg <= S_SH_WR;
                S_SH_WR: begin
                    if (up_reg) begin
                        if (idx_reg == pos_reg) begin
                            state_reg <= S_WRITE;
                        end else begin
                            idx_reg   <= idx_reg - 1'b1;
                            state_reg <= S_SH_RD;
                        end
                    end else if (idx_reg == used_reg) begin
                        state_reg <= S_CENTER;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SH_RD;
                    end
                end
                S_WRITE: state_reg <= S_CENTER;
                S_CENTER: begin
                    center_reg <= mid_sum[CW:1];
                    state_reg  <= S_OUT;
                end
                S_OUT: begin
                    if (!out_valid_reg || res_ready) begin
                        out_outcome_reg <= outcome_reg;
                        out_row_reg     <= 6'(row_out_reg);
                        out_count_reg   <= 7'(used_reg);
                        out_center_reg  <= 7'(center_reg);
                        state_reg       <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign res_valid   = out_valid_reg;
    assign res_outcome = out_outcome_reg;
    assign res_row     = out_row_reg;
    assign res_count   = out_count_reg;
    assign res_center  = out_center_reg;
endmodule

### sim/price_level_book_update_core_checker.sv
`timescale 1ns / 1ps
module price_level_book_update_core_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [4:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          fail_count,
    output int          pending
);
    import plbu_pkg::*;

    localparam int DEPTH = 64;

    typedef struct packed {
        logic [2:0] outcome;
        logic [5:0] row;
        logic [6:0] level_count;
        logic [6:0] center_row;
    } book_result_t;

    logic signed [31:0] lvl_price [DEPTH];
    logic [31:0]        lvl_qty   [DEPTH][4];
    int                 lvl_count;
    book_result_t       expected_q [$];

    assign pending = expected_q.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        fail_count++;
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic logic [6:0] book_center();
        int b;
        int a;
        b = lvl_count;
        a = 0;
        for (int i = 0; i < lvl_count; i++) begin
            if ((lvl_qty[i][0] | lvl_qty[i][2]) != 0 && i < b) b = i;
            if ((lvl_qty[i][1] | lvl_qty[i][3]) != 0 && i > a) a = i;
        end
        return 7'((b + a + 1) / 2);
    endfunction

    // Apply one request to the shadow book and return its result.
    function automatic book_result_t apply_update(input logic [1:0] op, input logic [2:0] et,
                                                  input logic signed [31:0] price,
                                                  input logic [31:0] qty);
        book_result_t r;
        bit found;
        int pos;
        found = 0;
        pos = 0;
        r.outcome = OUT_IGNORED;
        r.row = '0;
        if (op == OP_CLEAR) begin
            lvl_count = 0;
            r.outcome = OUT_CLEARED;
        end else if ((op == OP_SET || op == OP_DEL) && et <= ET_LAST) begin
            // scan from the lowest price upwards
            for (int i = lvl_count; i > 0; i--) begin
                if (lvl_price[i-1] == price) begin
                    found = 1;
                    pos = i - 1;
                    break;
                end
                if (price < lvl_price[i-1]) begin
                    pos = i;
                    break;
                end
            end
            if (op == OP_DEL) begin
                if (!found) begin
                    r.outcome = OUT_BAD_DELETE;
                end else begin
                    lvl_qty[pos][et] = '0;
                    r.row = 6'(pos);
                    if ((lvl_qty[pos][0] | lvl_qty[pos][1] | lvl_qty[pos][2]
                         | lvl_qty[pos][3]) == 0) begin
                        for (int i = pos; i < lvl_count - 1; i++) begin
                            lvl_price[i] = lvl_price[i+1];
                            lvl_qty[i] = lvl_qty[i+1];
                        end
                        lvl_count--;
                        r.outcome = OUT_REMOVED;
                    end else begin
                        r.outcome = OUT_UPDATED;
                    end
                end
            end else if (found) begin
                lvl_qty[pos][et] = qty;
                r.row = 6'(pos);
                r.outcome = OUT_UPDATED;
            end else if (lvl_count >= DEPTH) begin
                r.outcome = OUT_FULL;
            end else begin
                for (int i = lvl_count; i > pos; i--) begin
                    lvl_price[i] = lvl_price[i-1];
                    lvl_qty[i] = lvl_qty[i-1];
                end
                lvl_price[pos] = price;
                for (int k = 0; k < 4; k++) lvl_qty[pos][k] = '0;
                lvl_qty[pos][et] = qty;
                lvl_count++;
                r.row = 6'(pos);
                r.outcome = OUT_INSERTED;
            end
        end
        r.level_count = 7'(lvl_count);
        r.center_row = book_center();
        return r;
    endfunction

    always @(posedge aclk) begin
        book_result_t want;
        if (!aresetn) begin
            lvl_count = 0;
            expected_q.delete();
            fail_count = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_update(s_tuser[1:0], s_tuser[4:2],
                                                  s_tdata[31:0], s_tdata[63:32]));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result", 32'(m_tuser), 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_tuser != want.outcome)
                        report("outcome", 32'(m_tuser), 32'(want.outcome));
                    if (m_tdata[5:0] != want.row)
                        report("row", 32'(m_tdata[5:0]), 32'(want.row));
                    if (m_tdata[12:6] != want.level_count)
                        report("level_count", 32'(m_tdata[12:6]), 32'(want.level_count));
                    if (m_tdata[19:13] != want.center_row)
                        report("center_row", 32'(m_tdata[19:13]), 32'(want.center_row));
                    if (m_tdata[23:20] != '0)
                        report("pad bits", 32'(m_tdata[23:20]), 32'd0);
                end
            end
        end
    end
endmodule

### sim/price_level_book_update_core_tb.sv
`timescale 1ns / 1ps
module price_level_book_update_core_tb;
    import plbu_pkg::*;

    localparam int RANDOM_REQUESTS = 970;
    localparam int STALL_LIMIT     = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [4:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          active_prices [$];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    price_level_book_update_core u_dut (.*);

    price_level_book_update_core_checker u_chk (.*);

    // watchdog: count cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stalls in its own rhythm: runs of ready, runs of stall
    initial begin
        int run;
        forever begin
            run = $urandom_range(1, 12);
            m_tready <= ($urandom_range(0, 3) != 0);
            repeat (run) @(negedge aclk);
        end
    end

    int burst_left = 0;

    task automatic send(input logic [1:0] op, input logic [2:0] et,
                        input logic [31:0] price, input logic [31:0] qty);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 2) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= {et, op};
        s_tdata  <= {qty, price};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_price();
        // mostly prices already in the book, drawn from a narrow band
        if (active_prices.size() > 0 && $urandom_range(0, 9) < 6)
            return active_prices[$urandom_range(0, active_prices.size() - 1)];
        if ($urandom_range(0, 19) == 0) return $urandom;
        return 32'($signed(32'($urandom_range(0, 199))) - 100);
    endfunction

    initial begin
        logic [1:0]  op;
        logic [2:0]  et;
        logic [31:0] price;
        int          sel;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes, each operation, each special case
        send(OP_DEL, 3'd0, 32'd5, 32'd1);                  // delete on an empty book
        send(OP_SET, 3'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);   // highest price
        send(OP_SET, 3'd1, 32'h8000_0000, 32'hFFFF_FFFF);   // lowest price
        send(OP_SET, 3'd2, 32'd0, 32'd7);
        send(OP_SET, 3'd3, 32'd0, 32'd9);                   // update existing level
        send(OP_SET, 3'd4, 32'd3, 32'd1);                   // unknown entry type
        send(OP_SET, 3'd7, 32'd3, 32'd1);
        send(2'd3, 3'd0, 32'd3, 32'd1);                     // unknown operation
        send(OP_SET, 3'd1, 32'hFFFF_FFFF, 32'd0);           // zero quantity keeps the level
        send(OP_DEL, 3'd2, 32'd0, 32'd0);                   // level stays
        send(OP_DEL, 3'd3, 32'd0, 32'd0);                   // level goes
        send(OP_DEL, 3'd5, 32'd0, 32'd0);
        send(OP_DEL, 3'd0, 32'd1234, 32'd0);                // no such level
        send(OP_CLEAR, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // fill the book beyond its depth to hit the full case
        for (int i = 0; i < 66; i++)
            send(OP_SET, 3'(i % 4), 32'(i * 3 - 90), 32'(i + 1));
        send(OP_DEL, 3'd1, 32'd6, 32'd0);
        send(OP_CLEAR, 3'd0, 32'd0, 32'd0);

        // random: mostly well formed updates on a live band of prices
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            sel = $urandom_range(0, 99);
            price = pick_price();
            et = 3'($urandom_range(0, 3));
            if (sel < 55) op = OP_SET;
            else if (sel < 90) op = OP_DEL;
            else if (sel < 92) op = OP_CLEAR;
            else begin
                op = 2'($urandom_range(0, 3));
                et = 3'($urandom);
            end
            if (op == OP_SET && et <= ET_LAST) active_prices.push_back(price);
            if (op == OP_CLEAR) active_prices.delete();
            if (active_prices.size() > 80) active_prices.delete(0);
            send(op, et, price, $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 3)));
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
